[rtl/vst_pkg.sv]
// Shared constants, codes and types of the versioned slot table.
`timescale 1ns / 1ps

package vst_pkg;

  localparam int NUM_SLOTS       = 64;
  localparam int GENERATION_BITS = 32;
  localparam int SLOT_AW         = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W           = 8;
  localparam int TAG_W           = 32;
  localparam int TIME_W          = 64;
  localparam int ENTRY_W         = GENERATION_BITS + TIME_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_GET     = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_STALE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_AW-1:0] slot;
  } free_slot_t;

endpackage

[rtl/vst_free_find.sv]
// Priority encoder that finds the lowest free slot from the busy flags.
`timescale 1ns / 1ps

module vst_free_find
  import vst_pkg::*;
(
  input  logic [NUM_SLOTS-1:0] slot_busy,
  output free_slot_t           free_slot
);

  always_comb begin
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_slot.found = 1'b1;
        free_slot.slot  = SLOT_AW'(i);
      end
    end
  end

endmodule

[rtl/versioned_slot_table_unit.sv]
// Top level of the versioned slot table: request control, slot memory and result register.
`timescale 1ns / 1ps

// For each request, the cycle in which start is taken reads the slot entry
// from the synchronous slot memory, and the following cycle, with busy high, checks the tag,
// writes the entry back and loads the result. The result strobe out_valid is high for one
// cycle right after that, and a new request may be started in that same cycle. The receiver
// cannot stall, so every result must be captured in its strobe cycle. Reset takes effect at
// once; there is no clearing sweep of the memory.
module versioned_slot_table_unit
  import vst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [TAG_W-1:0]  in_version_tag,
  input  logic [TIME_W-1:0] in_commit_time,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_result_slot,
  output logic [TAG_W-1:0]  out_result_version,
  output logic [TIME_W-1:0] out_result_time
);

  state_t state_r, state_nxt;

  logic [NUM_SLOTS-1:0]  slot_busy_r;
  logic [NUM_SLOTS-1:0]  entry_vld_r;
  logic [ENTRY_W-1:0]    slot_mem [NUM_SLOTS];

  opcode_t             op_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TAG_W-1:0]    tag_r;
  logic [TIME_W-1:0]   time_r;
  logic [SLOT_AW-1:0]  addr_r;
  logic                found_r;
  logic                invalid_r;
  logic                ent_vld_r;
  logic [ENTRY_W-1:0]  rd_data_r;

  logic                out_valid_r;
  status_t             res_status_r;
  logic [IDX_W-1:0]    res_slot_r;
  logic [TAG_W-1:0]    res_version_r;
  logic [TIME_W-1:0]   res_time_r;

  free_slot_t          free_slot;
  logic                accept;
  logic [SLOT_AW-1:0]  rd_addr;
  logic                in_invalid;

  logic [GENERATION_BITS-1:0] gen_cur;
  logic [GENERATION_BITS-1:0] gen_new;
  logic [TIME_W-1:0]          time_cur;
  logic                       tag_match;

  logic                       wr_en;
  logic [GENERATION_BITS-1:0] wr_gen;
  logic [TIME_W-1:0]          wr_time;
  logic                       set_busy;
  logic                       clr_busy;
  status_t                    res_status;
  logic [IDX_W-1:0]           res_slot;
  logic [TAG_W-1:0]           res_version;
  logic [TIME_W-1:0]          res_time;

  vst_free_find u_free_find (
    .slot_busy (slot_busy_r),
    .free_slot (free_slot)
  );

  assign busy       = (state_r == ST_EXEC);
  assign accept     = start && !busy;
  assign in_invalid = ({1'b0, in_slot_index} >= (IDX_W + 1)'(NUM_SLOTS));
  assign rd_addr    = (opcode_t'(in_opcode) == OP_ALLOC) ? free_slot.slot
                                                         : in_slot_index[SLOT_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A slot entry that was never written since reset reads as zero.
  assign gen_cur   = ent_vld_r ? rd_data_r[ENTRY_W-1:TIME_W] : '0;
  assign time_cur  = ent_vld_r ? rd_data_r[TIME_W-1:0] : '0;
  assign gen_new   = gen_cur + 1'b1;
  assign tag_match = (TAG_W'(gen_cur) == tag_r);

  always_comb begin
    wr_en       = 1'b0;
    wr_gen      = gen_cur;
    wr_time     = time_cur;
    set_busy    = 1'b0;
    clr_busy    = 1'b0;
    res_status  = STAT_OK;
    res_slot    = idx_r;
    res_version = '0;
    res_time    = '0;
    priority if (op_r == OP_ALLOC) begin
      res_slot = '0;
      if (found_r) begin
        wr_en       = 1'b1;
        wr_gen      = gen_new;
        wr_time     = '0;
        set_busy    = 1'b1;
        res_slot    = IDX_W'(addr_r);
        res_version = TAG_W'(gen_new);
      end else begin
        res_status = STAT_NO_FREE;
      end
    end else if (invalid_r) begin
      res_status = STAT_BAD_INDEX;
    end else if (!tag_match) begin
      res_status = STAT_STALE;
      if (op_r == OP_GET) begin
        res_time = TIME_W'(1);
      end
    end else if (op_r == OP_UPDATE) begin
      wr_en   = 1'b1;
      wr_time = time_r;
    end else if (op_r == OP_GET) begin
      res_time = time_cur;
    end else begin
      clr_busy = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_busy_r <= '0;
      entry_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (busy && wr_en) begin
        entry_vld_r[addr_r] <= 1'b1;
      end
      if (busy && set_busy) begin
        slot_busy_r[addr_r] <= 1'b1;
      end
      if (busy && clr_busy) begin
        slot_busy_r[addr_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= opcode_t'(in_opcode);
      idx_r     <= in_slot_index;
      tag_r     <= in_version_tag;
      time_r    <= in_commit_time;
      addr_r    <= rd_addr;
      found_r   <= free_slot.found;
      invalid_r <= in_invalid;
      ent_vld_r <= entry_vld_r[rd_addr];
    end
    if (busy) begin
      res_status_r  <= res_status;
      res_slot_r    <= res_slot;
      res_version_r <= res_version;
      res_time_r    <= res_time;
    end
  end

  // The read happens at the start transfer and the write in the cycle after it, so they never collide.
  always_ff @(posedge clk) begin
    if (busy && wr_en) begin
      slot_mem[addr_r] <= {wr_gen, wr_time};
    end
    if (accept) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_status_r;
  assign out_result_slot    = res_slot_r;
  assign out_result_version = res_version_r;
  assign out_result_time    = res_time_r;

`ifndef SYNTHESIS
  a_start_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("Accepted request did not enter the execute cycle.");

  a_exec_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid_r && !busy))
    else $error("Execute cycle was not followed by exactly one result strobe.");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("Result strobe without a preceding execute cycle.");

  a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && set_busy) |=> slot_busy_r[addr_r])
    else $error("Granted slot is not marked busy after allocation.");
`endif

endmodule

[tb/slot_table_checker.sv]
// Checker for the versioned slot table: tracks the slot contents, predicts every result and compares.
`timescale 1ns / 1ps

module slot_table_checker
  import vst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [TAG_W-1:0]  in_version_tag,
  input  logic [TIME_W-1:0] in_commit_time,
  input  logic              out_valid,
  input  logic [1:0]        out_status,
  input  logic [IDX_W-1:0]  out_result_slot,
  input  logic [TAG_W-1:0]  out_result_version,
  input  logic [TIME_W-1:0] out_result_time,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [TAG_W-1:0]   version;
    logic [TIME_W-1:0]  stamp;
  } slot_reply_t;

  logic                       slot_taken [NUM_SLOTS];
  logic [GENERATION_BITS-1:0] slot_gen   [NUM_SLOTS];
  logic [TIME_W-1:0]          slot_stamp [NUM_SLOTS];
  slot_reply_t                replies_due[$];
  slot_reply_t                want;

  function automatic slot_reply_t apply_request(opcode_t op, logic [IDX_W-1:0] idx,
                                                logic [TAG_W-1:0] tag,
                                                logic [TIME_W-1:0] stamp);
    slot_reply_t reply;
    logic        granted;
    reply.status  = STAT_OK;
    reply.slot    = idx;
    reply.version = '0;
    reply.stamp   = '0;
    granted       = 1'b0;
    if (op == OP_ALLOC) begin
      reply.slot   = '0;
      reply.status = STAT_NO_FREE;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (!granted && !slot_taken[s]) begin
          granted       = 1'b1;
          slot_taken[s] = 1'b1;
          slot_gen[s]   = slot_gen[s] + 1'b1;
          slot_stamp[s] = '0;
          reply.status  = STAT_OK;
          reply.slot    = IDX_W'(s);
          reply.version = TAG_W'(slot_gen[s]);
        end
      end
    end else if (int'(idx) >= NUM_SLOTS) begin
      reply.status = STAT_BAD_INDEX;
    end else if (TAG_W'(slot_gen[idx]) != tag) begin
      reply.status = STAT_STALE;
      if (op == OP_GET) begin
        reply.stamp = TIME_W'(1);
      end
    end else begin
      case (op)
        OP_UPDATE: slot_stamp[idx] = stamp;
        OP_GET:    reply.stamp = slot_stamp[idx];
        default:   slot_taken[idx] = 1'b0;
      endcase
    end
    return reply;
  endfunction

  task automatic check_field(input string field, input logic [TIME_W-1:0] expected,
                             input logic [TIME_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 'h%0h, actual 'h%0h", field, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_taken[s] = 1'b0;
        slot_gen[s]   = '0;
        slot_stamp[s] = '0;
      end
      replies_due.delete();
    end else begin
      // The result of an earlier transfer is compared before this edge's request is applied.
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", TIME_W'(want.status), TIME_W'(out_status));
          check_field("result_slot", TIME_W'(want.slot), TIME_W'(out_result_slot));
          check_field("result_version", TIME_W'(want.version), TIME_W'(out_result_version));
          check_field("result_time", want.stamp, out_result_time);
        end
      end
      if (start && !busy) begin
        replies_due.push_back(apply_request(opcode_t'(in_opcode), in_slot_index,
                                            in_version_tag, in_commit_time));
      end
    end
    outstanding = replies_due.size();
  end

endmodule

[tb/testbench.sv]
// Top of the versioned slot table testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench
  import vst_pkg::*;
();

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [IDX_W-1:0]  in_slot_index;
  logic [TAG_W-1:0]  in_version_tag;
  logic [TIME_W-1:0] in_commit_time;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [IDX_W-1:0]  out_result_slot;
  logic [TAG_W-1:0]  out_result_version;
  logic [TIME_W-1:0] out_result_time;
  int                fail_count;
  int                outstanding;

  // Handles granted by the block and not yet released, and a few recently released ones.
  logic [IDX_W-1:0]  live_slot[$];
  logic [TAG_W-1:0]  live_gen[$];
  logic [IDX_W-1:0]  freed_slot[$];
  logic [TAG_W-1:0]  freed_gen[$];
  opcode_t           issued_ops[$];
  opcode_t           done_op;
  int                status_tally[4];
  int                full_hits;
  int                full_mark;
  int                sender_idle_pct;
  int                requests_sent;
  int                directed_count;
  bit                filling;

  versioned_slot_table_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_slot_index      (in_slot_index),
    .in_version_tag     (in_version_tag),
    .in_commit_time     (in_commit_time),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_slot    (out_result_slot),
    .out_result_version (out_result_version),
    .out_result_time    (out_result_time)
  );

  slot_table_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_slot_index      (in_slot_index),
    .in_version_tag     (in_version_tag),
    .in_commit_time     (in_commit_time),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_slot    (out_result_slot),
    .out_result_version (out_result_version),
    .out_result_time    (out_result_time),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Follows the results so that later requests can name slots the block really handed out.
  always @(posedge clk) begin
    if (rst_n && out_valid && issued_ops.size() != 0) begin
      done_op = issued_ops.pop_front();
      status_tally[out_status]++;
      if (done_op == OP_ALLOC && out_status == STAT_OK) begin
        live_slot.push_back(out_result_slot);
        live_gen.push_back(out_result_version);
      end
      if (done_op == OP_ALLOC && out_status == STAT_NO_FREE) begin
        full_hits++;
      end
      if (done_op == OP_RELEASE && out_status == STAT_OK) begin
        for (int k = live_slot.size() - 1; k >= 0; k--) begin
          if (live_slot[k] == out_result_slot) begin
            freed_slot.push_back(live_slot[k]);
            freed_gen.push_back(live_gen[k]);
            live_slot.delete(k);
            live_gen.delete(k);
          end
        end
        if (freed_slot.size() > 16) begin
          void'(freed_slot.pop_front());
          void'(freed_gen.pop_front());
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer was accepted.
  task automatic send_request(input opcode_t op, input logic [IDX_W-1:0] idx,
                              input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_slot_index  <= idx;
    in_version_tag <= tag;
    in_commit_time <= stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued_ops.push_back(op);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_request();
    opcode_t           op;
    logic [IDX_W-1:0]  idx;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
    int                r;
    int                k;
    // Alternate between filling the table up to exhaustion and draining it again.
    if (filling && (live_slot.size() >= NUM_SLOTS || full_hits != full_mark)) begin
      filling = 1'b0;
    end else if (!filling && live_slot.size() < 12) begin
      filling   = 1'b1;
      full_mark = full_hits;
    end
    r = $urandom_range(0, 99);
    if (filling) begin
      op = (r < 70) ? OP_ALLOC : (r < 78) ? OP_UPDATE : (r < 90) ? OP_GET : OP_RELEASE;
    end else begin
      op = (r < 10) ? OP_ALLOC : (r < 28) ? OP_UPDATE : (r < 55) ? OP_GET : OP_RELEASE;
    end
    r = $urandom_range(0, 99);
    if (r < 72 && live_slot.size() != 0) begin
      k   = $urandom_range(0, live_slot.size() - 1);
      idx = live_slot[k];
      tag = live_gen[k];
    end else if (r < 80 && freed_slot.size() != 0) begin
      k   = $urandom_range(0, freed_slot.size() - 1);
      idx = freed_slot[k];
      tag = freed_gen[k];
    end else if (r < 88) begin
      if (live_slot.size() != 0) begin
        k   = $urandom_range(0, live_slot.size() - 1);
        idx = live_slot[k];
        tag = live_gen[k] + 1'b1;
      end else begin
        idx = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        tag = $urandom;
      end
      if ($urandom_range(0, 2) == 0) begin
        tag = '1;
      end
    end else if (r < 94) begin
      idx = IDX_W'($urandom_range(NUM_SLOTS, 255));
      tag = $urandom;
    end else begin
      idx = IDX_W'($urandom_range(0, 255));
      tag = TAG_W'($urandom_range(0, 3));
    end
    r = $urandom_range(0, 9);
    stamp = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
    send_request(op, idx, tag, stamp);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_ALLOC;
    in_slot_index   = '0;
    in_version_tag  = '0;
    in_commit_time  = '0;
    sender_idle_pct = 0;
    requests_sent   = 0;
    full_hits       = 0;
    full_mark       = 0;
    filling         = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Untouched slot 0 has generation zero, so a zero tag matches while it is free.
    send_request(OP_GET,     8'd0,   32'd0, 64'd0);
    send_request(OP_UPDATE,  8'd0,   32'd0, '1);
    send_request(OP_GET,     8'd0,   32'd0, 64'd0);
    send_request(OP_RELEASE, 8'd0,   32'd0, 64'd0);
    send_request(OP_ALLOC,   8'd0,   32'd0, 64'd0);
    send_request(OP_GET,     8'd0,   32'd1, 64'd0);
    send_request(OP_UPDATE,  8'd0,   32'd1, 64'h0123_4567_89ab_cdef);
    send_request(OP_GET,     8'd0,   32'd1, '1);
    send_request(OP_GET,     8'd0,   32'd0, 64'd0);
    send_request(OP_UPDATE,  8'd0,   '1,    64'h5555_5555_5555_5555);
    send_request(OP_RELEASE, 8'd0,   32'd2, 64'd0);
    send_request(OP_GET,     8'(NUM_SLOTS - 1), 32'd0, 64'd0);
    send_request(OP_UPDATE,  8'(NUM_SLOTS),     32'd0, '1);
    send_request(OP_GET,     8'(NUM_SLOTS),     32'd0, 64'd0);
    send_request(OP_RELEASE, 8'd255, 32'd0, 64'd0);
    send_request(OP_GET,     8'd255, '1,    '1);
    send_request(OP_ALLOC,   8'd255, '1,    '1);
    send_request(OP_RELEASE, 8'd0,   32'd1, 64'd0);
    send_request(OP_ALLOC,   8'd0,   32'd0, 64'd0);
    send_request(OP_GET,     8'd0,   32'd2, 64'd0);
    send_request(OP_UPDATE,  8'd255, 32'd0, '1);
    send_request(OP_ALLOC,   8'd0,   32'd0, 64'd0);
    directed_count = requests_sent;

    for (int stretch = 0; stretch < 6; stretch++) begin
      sender_idle_pct = (stretch % 3 == 0) ? 0 : (stretch % 3 == 1) ? 53 : 6;
      repeat (72) send_random_request();
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("testbench: %0d request transfers (%0d directed), table found full %0d times",
             requests_sent, directed_count, full_hits);
    $display("testbench: results ok %0d, no free slot %0d, bad index %0d, stale tag %0d",
             status_tally[STAT_OK], status_tally[STAT_NO_FREE],
             status_tally[STAT_BAD_INDEX], status_tally[STAT_STALE]);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/vst_pkg.sv
rtl/vst_free_find.sv
rtl/versioned_slot_table_unit.sv
tb/slot_table_checker.sv
tb/testbench.sv
